>>> design/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int JOB_BYTES = 8;
	localparam int JOB_W     = JOB_BYTES * 8;
	localparam int LEN_W     = 4;
	localparam int TOTAL_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LEN   = 2'd0,
		CFG_PATTERN_BYTES = 2'd1,
		CFG_REPLACE_LEN   = 2'd2,
		CFG_REPLACE_BYTES = 2'd3
	} cfg_reg_t;

	// One queued burst of output bytes; byte 0 goes out first.
	typedef struct packed {
		logic [JOB_W-1:0]   bytes;
		logic [LEN_W-1:0]   cnt;
		logic [TOTAL_W-1:0] total;
	} job_t;

endpackage

>>> design/sfr_front.sv
// Front end: config registers, match window, compare and job build.
module sfr_front #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_stream,
	input  logic                      q_full,
	output logic                      q_push,
	output sfr_pkg::job_t             q_job
);
	import sfr_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_MAX + 1);

	logic [7:0]         win_q [PATTERN_MAX];
	logic [FILL_W-1:0]  fill_q;
	logic [TOTAL_W-1:0] count_q;
	logic [LEN_W-1:0]   pat_len_q;
	logic [JOB_W-1:0]   pat_q;
	logic [LEN_W-1:0]   rep_len_q;
	logic [JOB_W-1:0]   rep_q;

	logic [7:0]         win_new [PATTERN_MAX];
	logic [7:0]         win_sh  [PATTERN_MAX];
	logic [JOB_W-1:0]   win_pack;
	logic [FILL_W-1:0]  eff_len;
	logic [FILL_W-1:0]  fill_c;
	logic [FILL_W-1:0]  fill_new;
	logic               full;
	logic               eq_all;
	logic               hit;
	logic [LEN_W-1:0]   rep_n;
	logic [TOTAL_W-1:0] cnt_next;
	logic               accept;
	logic               cfg_len_wr;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign cfg_len_wr = cfg_valid && cfg_ready && (cfg_reg_t'(cfg_index) == CFG_PATTERN_LEN);

	always_comb begin
		if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			eff_len = FILL_W'(PATTERN_MAX);
		end else begin
			eff_len = FILL_W'(pat_len_q);
		end
	end

	// clamp guards a window left fuller than the current length
	assign fill_c   = (fill_q >= eff_len) ? (eff_len - 1'b1) : fill_q;
	assign fill_new = fill_c + 1'b1;
	assign full     = (fill_new == eff_len);
	assign rep_n    = (rep_len_q > LEN_W'(JOB_BYTES)) ? LEN_W'(JOB_BYTES) : rep_len_q;

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_new[i] = (fill_c == FILL_W'(i)) ? data_byte : win_q[i];
		end
		for (int i = 0; i < PATTERN_MAX - 1; i++) begin
			win_sh[i] = win_new[i + 1];
		end
		win_sh[PATTERN_MAX-1] = win_new[PATTERN_MAX-1];
	end

	always_comb begin
		win_pack = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_pack[8*i +: 8] = win_new[i];
		end
	end

	// parallel byte compare over the active pattern length
	always_comb begin
		eq_all = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (FILL_W'(i) < eff_len && win_new[i] != pat_q[8*i +: 8]) begin
				eq_all = 1'b0;
			end
		end
	end

	assign hit = (eff_len != '0) && full && eq_all;

	always_comb begin
		if (hit && count_q != {TOTAL_W{1'b1}}) begin
			cnt_next = count_q + 1'b1;
		end else begin
			cnt_next = count_q;
		end
	end

	always_comb begin
		q_job.total = cnt_next;
		q_job.bytes = win_pack;
		q_job.cnt   = '0;
		if (eff_len == '0) begin
			q_job.bytes = {{(JOB_W-8){1'b0}}, data_byte};
			q_job.cnt   = LEN_W'(1);
		end else if (hit) begin
			q_job.bytes = rep_q;
			q_job.cnt   = rep_n;
		end else if (end_of_stream) begin
			q_job.cnt   = LEN_W'(fill_new);
		end else if (full) begin
			q_job.cnt   = LEN_W'(1);
		end
	end

	assign q_push = accept && (q_job.cnt != '0);

	always_ff @(posedge clk) begin
		if (accept && eff_len != '0) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= (full && !hit) ? win_sh[i] : win_new[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			count_q   <= '0;
			pat_len_q <= '0;
			pat_q     <= '0;
			rep_len_q <= '0;
			rep_q     <= '0;
		end else begin
			// a new pattern length drops whatever the window still holds
			if (cfg_len_wr) begin
				fill_q <= '0;
			end else if (accept && eff_len != '0) begin
				if (hit || end_of_stream) begin
					fill_q <= '0;
				end else if (full) begin
					fill_q <= fill_new - 1'b1;
				end else begin
					fill_q <= fill_new;
				end
			end
			if (accept) begin
				count_q <= cnt_next;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PATTERN_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
					CFG_PATTERN_BYTES: pat_q <= cfg_data;
					CFG_REPLACE_LEN: rep_len_q <= cfg_data[LEN_W-1:0];
					CFG_REPLACE_BYTES: rep_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

>>> design/sfr_queue.sv
// Small job FIFO between front and back ends.
module sfr_queue #(
	parameter int DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output sfr_pkg::job_t pop_job,
	output logic          empty
);
	import sfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/sfr_back.sv
// Back end: serializes queued jobs into output byte transfers.
module sfr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  sfr_pkg::job_t               q_job,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        run_last,
	output logic [sfr_pkg::TOTAL_W-1:0] match_total
);
	import sfr_pkg::*;

	logic [JOB_W-1:0]   bytes_q;
	logic [LEN_W-1:0]   left_q;
	logic [TOTAL_W-1:0] total_q;
	logic               busy_q;
	logic               fire;
	logic               last;

	assign fire        = busy_q && out_ready;
	assign last        = (left_q == LEN_W'(1));
	assign q_pop       = !q_empty && (!busy_q || (fire && last));
	assign out_valid   = busy_q;
	assign out_byte    = bytes_q[7:0];
	assign run_last    = last;
	assign match_total = total_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bytes_q <= q_job.bytes;
			total_q <= q_job.total;
		end else if (fire) begin
			bytes_q <= {8'h00, bytes_q[JOB_W-1:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				left_q <= q_job.cnt;
			end else if (fire) begin
				busy_q <= !last;
				left_q <= left_q - 1'b1;
			end
		end
	end

endmodule

>>> design/stream_find_replace_top.sv
// Stream find-and-replace: top level joining front end, job queue and back end.
// A job built from an accepted byte is written to the queue, then loaded into the back end.
// Throughput: one input byte per cycle; an output burst holds the back end until its last
// byte is sent, and the front keeps taking bytes until the queue (depth 4 by default) fills.
// Reset: arst_n clears window fill, match count, config registers and the queue.
module stream_find_replace_top #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
	parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
	// input byte stream
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_stream,
	// output byte stream
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          run_last,
	output logic [sfr_pkg::TOTAL_W-1:0]   match_total
);
	import sfr_pkg::*;

	// Each accepted input byte becomes zero or one job: a burst of up to
	// eight bytes (pass-through byte, oldest window byte, replacement text,
	// or the window flush at end of stream) tagged with the match count.
	job_t push_job;
	job_t pop_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// Front: combinational window update, pattern compare and job build per accepted byte.
	sfr_front #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_full        (q_full),
		.q_push        (push),
		.q_job         (push_job)
	);

	// Queue decouples the byte-per-cycle front (held while the queue is full) from multi-byte bursts.
	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// Back: from registered job state, one output transfer per cycle while busy and out_ready is high.
	sfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (pop_job),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.match_total (match_total)
	);

endmodule
